@@ rtl/bresenham_line_pixel_writer_unit_defines.svh @@
// Assertion macros shared by the line pixel writer RTL.
`ifndef BRESENHAM_LINE_PIXEL_WRITER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
// Next-cycle implication, checked outside reset.
`ifndef SYNTH
`define BLPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BLPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLPW_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BLPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/blpw_pkg.sv @@
// Types and constants shared by the line pixel writer modules.
package blpw_pkg;

   localparam int COORD_X_W    = 9;
   localparam int COORD_Y_W    = 8;
   localparam int COLOR_W      = 8;
   localparam int ADDR_W       = 16;
   localparam int COUNT_W      = 4;
   localparam int SLOTS        = 8;
   localparam int MAX_GROUPS   = 40;
   localparam int GROUP_CNT_W  = 6;
   localparam int DEC_W        = 12;
   localparam int TOTAL_W      = 10;
   localparam int QUEUE_DEPTH  = 2;

   // One line command as it arrives.
   typedef struct packed {
      logic [COORD_X_W-1:0] x_start;
      logic [COORD_Y_W-1:0] y_start;
      logic [COORD_X_W-1:0] x_end;
      logic [COORD_Y_W-1:0] y_end;
      logic [COLOR_W-1:0]   pixel_color;
   } req_type;

   // One group of pixel addresses as it leaves.
   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_addr_0;
      logic [ADDR_W-1:0]  pixel_addr_1;
      logic [ADDR_W-1:0]  pixel_addr_2;
      logic [ADDR_W-1:0]  pixel_addr_3;
      logic [ADDR_W-1:0]  pixel_addr_4;
      logic [ADDR_W-1:0]  pixel_addr_5;
      logic [ADDR_W-1:0]  pixel_addr_6;
      logic [ADDR_W-1:0]  pixel_addr_7;
      logic [COUNT_W-1:0] pixel_count;
      logic [COLOR_W-1:0] write_color;
      logic               last_group;
   } rsp_type;

   // Prepared walk of one line, handed from the front to the walker.
   typedef struct packed {
      logic [ADDR_W-1:0]        start_addr;
      logic signed [DEC_W-1:0]  dec_init;
      logic signed [DEC_W-1:0]  inc_straight;
      logic signed [DEC_W-1:0]  inc_diag;
      logic [ADDR_W-1:0]        delta_straight;
      logic [ADDR_W-1:0]        delta_diag;
      logic [TOTAL_W-1:0]       total;
      logic [COLOR_W-1:0]       color;
   } line_desc_type;

endpackage

@@ rtl/blpw_front.sv @@
// Front end: accepts line commands, clamps them and prepares the walk.
module blpw_front #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 200
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  blpw_pkg::req_type       req_data,
   input  logic                    q_full,
   output logic                    push,
   output blpw_pkg::line_desc_type desc
);
   import blpw_pkg::*;

   localparam int XMAX = (1 << COORD_X_W) - 1;
   localparam int YMAX = (1 << COORD_Y_W) - 1;
   localparam int XLIM = (SCREEN_W - 1 > XMAX) ? XMAX : SCREEN_W - 1;
   localparam int YLIM = (SCREEN_H - 1 > YMAX) ? YMAX : SCREEN_H - 1;
   localparam logic [COORD_X_W-1:0] XLIM_C   = COORD_X_W'(XLIM);
   localparam logic [COORD_Y_W-1:0] YLIM_C   = COORD_Y_W'(YLIM);
   localparam logic [ADDR_W-1:0]    ROW_STEP = ADDR_W'(SCREEN_W);

   logic                 s1_valid_ff;
   logic [COORD_X_W-1:0] x0_ff, x1_ff;
   logic [COORD_Y_W-1:0] y0_ff, y1_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic                 accept;

   logic                 x_neg, y_neg, x_major;
   logic [COORD_X_W-1:0] dx, dy, major, minor;
   logic [ADDR_W-1:0]    row_base, x_step, y_step, maj_step, min_step;
   logic [DEC_W-1:0]     two_minor, two_major;

   // The holding stage frees up as soon as its item moves into the queue.
   assign busy   = s1_valid_ff && q_full;
   assign accept = start && !busy;
   assign push   = s1_valid_ff && !q_full;

   // Holding stage: clamp coordinates onto the screen.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (push) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         x0_ff    <= (req_data.x_start > XLIM_C) ? XLIM_C : req_data.x_start;
         x1_ff    <= (req_data.x_end > XLIM_C) ? XLIM_C : req_data.x_end;
         y0_ff    <= (req_data.y_start > YLIM_C) ? YLIM_C : req_data.y_start;
         y1_ff    <= (req_data.y_end > YLIM_C) ? YLIM_C : req_data.y_end;
         color_ff <= req_data.pixel_color;
      end
   end

   // Classify the line and derive the decision terms and address steps.
   always_comb begin
      x_neg   = x1_ff < x0_ff;
      y_neg   = y1_ff < y0_ff;
      dx      = x_neg ? x0_ff - x1_ff : x1_ff - x0_ff;
      dy      = y_neg ? COORD_X_W'(y0_ff - y1_ff) : COORD_X_W'(y1_ff - y0_ff);
      x_major = dx >= dy;
      major   = x_major ? dx : dy;
      minor   = x_major ? dy : dx;

      two_minor = {2'b00, minor, 1'b0};
      two_major = {2'b00, major, 1'b0};

      row_base = ADDR_W'(ADDR_W'(y0_ff) * ROW_STEP);
      x_step   = x_neg ? {ADDR_W{1'b1}} : ADDR_W'(1);
      y_step   = y_neg ? ADDR_W'(0) - ROW_STEP : ROW_STEP;
      maj_step = x_major ? x_step : y_step;
      min_step = x_major ? y_step : x_step;

      desc.start_addr     = row_base + ADDR_W'(x0_ff);
      desc.dec_init       = $signed(two_minor) - $signed({3'b000, major});
      desc.inc_straight   = $signed(two_minor);
      desc.inc_diag       = $signed(two_minor) - $signed(two_major);
      desc.delta_straight = maj_step;
      desc.delta_diag     = maj_step + min_step;
      desc.total          = TOTAL_W'(major) + TOTAL_W'(1);
      desc.color          = color_ff;
   end

endmodule

@@ rtl/blpw_queue.sv @@
// Short register queue of prepared lines between the front and the walker.
`include "bresenham_line_pixel_writer_unit_defines.svh"
module blpw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  blpw_pkg::line_desc_type push_data,
   input  logic                    pop,
   output blpw_pkg::line_desc_type pop_data,
   output logic                    full,
   output logic                    empty
);
   import blpw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   line_desc_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full     = count_ff == DEPTH_C;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointers wrap at the queue depth; the count tracks occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Occupancy never passes the depth, and a pop from one item empties it.
   `BLPW_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= DEPTH_C, "queue overfilled")
   `BLPW_ASSERT_NEXT(a_pop_last_empties, clock, reset, do_pop && !do_push && count_ff == CNT_W'(1), empty, "queue not empty after last pop")

endmodule

@@ rtl/blpw_walker.sv @@
// Back end: walks a prepared line; in ST_RUN emits a pixel address group per cycle.
`include "bresenham_line_pixel_writer_unit_defines.svh"
module blpw_walker #(
   parameter int PIXELS_PER_GROUP = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    pop,
   input  blpw_pkg::line_desc_type desc,
   output logic                    rsp_valid,
   output blpw_pkg::rsp_type       rsp_data
);
   import blpw_pkg::*;

   localparam logic [TOTAL_W-1:0]     PPG_T     = TOTAL_W'(PIXELS_PER_GROUP);
   localparam logic [COUNT_W-1:0]     PPG_C     = COUNT_W'(PIXELS_PER_GROUP);
   localparam logic [GROUP_CNT_W-1:0] LAST_GRP  = GROUP_CNT_W'(MAX_GROUPS - 1);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   logic [ADDR_W-1:0]       addr_ff, delta_straight_ff, delta_diag_ff;
   logic signed [DEC_W-1:0] dec_ff, inc_straight_ff, inc_diag_ff;
   logic [TOTAL_W-1:0]      rem_ff;
   logic [GROUP_CNT_W-1:0]  grp_ff;
   logic [COLOR_W-1:0]      color_ff;

   logic [ADDR_W-1:0]       addr_in;
   logic signed [DEC_W-1:0] dec_in;
   logic                    last_in;
   logic [COUNT_W-1:0]      cnt_in;
   logic [ADDR_W-1:0]       slot [SLOTS];
   rsp_type                 rsp_in;

   assign pop       = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One group of Bresenham steps: each step records the address, then
   // moves straight or diagonally by the sign of the decision term.
   always_comb begin
      last_in = (rem_ff <= PPG_T) || (grp_ff == LAST_GRP);
      cnt_in  = (rem_ff <= PPG_T) ? COUNT_W'(rem_ff) : PPG_C;
      addr_in = addr_ff;
      dec_in  = dec_ff;
      for (int k = 0; k < SLOTS; k++) begin
         slot[k] = '0;
      end
      for (int k = 0; k < PIXELS_PER_GROUP; k++) begin
         if (COUNT_W'(k) < cnt_in) begin
            slot[k] = addr_in;
         end
         if (!dec_in[DEC_W-1]) begin
            addr_in = addr_in + delta_diag_ff;
            dec_in  = dec_in + inc_diag_ff;
         end else begin
            addr_in = addr_in + delta_straight_ff;
            dec_in  = dec_in + inc_straight_ff;
         end
      end
      rsp_in.pixel_addr_0 = slot[0];
      rsp_in.pixel_addr_1 = slot[1];
      rsp_in.pixel_addr_2 = slot[2];
      rsp_in.pixel_addr_3 = slot[3];
      rsp_in.pixel_addr_4 = slot[4];
      rsp_in.pixel_addr_5 = slot[5];
      rsp_in.pixel_addr_6 = slot[6];
      rsp_in.pixel_addr_7 = slot[7];
      rsp_in.pixel_count  = cnt_in;
      rsp_in.write_color  = color_ff;
      rsp_in.last_group   = last_in;
   end

   // Sequencer: load a line from the queue, then emit its groups back to back.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (!q_empty) begin
                  addr_ff           <= desc.start_addr;
                  dec_ff            <= desc.dec_init;
                  inc_straight_ff   <= desc.inc_straight;
                  inc_diag_ff       <= desc.inc_diag;
                  delta_straight_ff <= desc.delta_straight;
                  delta_diag_ff     <= desc.delta_diag;
                  rem_ff            <= desc.total;
                  grp_ff            <= '0;
                  color_ff          <= desc.color;
                  state_ff          <= ST_RUN;
               end
            end
            ST_RUN: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= rsp_in;
               addr_ff      <= addr_in;
               dec_ff       <= dec_in;
               rem_ff       <= rem_ff - PPG_T;
               grp_ff       <= grp_ff + GROUP_CNT_W'(1);
               if (last_in) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A flagged final group is followed by a gap, and counts stay in range.
   `BLPW_ASSERT_NEXT(a_last_then_gap, clock, reset, rsp_valid_ff && rsp_ff.last_group, !rsp_valid_ff, "group follows the final group without a gap")
   `BLPW_ASSERT_NOW(a_count_range, clock, reset, rsp_valid_ff, rsp_ff.pixel_count != '0 && rsp_ff.pixel_count <= PPG_C, "pixel count out of range")

endmodule

@@ rtl/bresenham_line_pixel_writer_unit.sv @@
// Top level of the Bresenham line pixel writer.
// A command is taken when start is high and busy is low; busy rises only when
// the two-entry line queue and the front holding stage are both occupied. Each
// line produces ceil((max(|dx|,|dy|)+1) / PIXELS_PER_GROUP) groups, at most 40,
// one group per clock on rsp_valid, with last_group set on the final one. The
// walker loads each line from the queue in its idle state, leaving a gap on
// rsp_valid between lines. When idle, a command passes the front holding stage,
// the queue and the walker load state before its first group is registered.
// Results are strobed for a single cycle and must be captured then.
module bresenham_line_pixel_writer_unit #(
   parameter int SCREEN_W         = 320,
   parameter int SCREEN_H         = 200,
   parameter int PIXELS_PER_GROUP = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  blpw_pkg::req_type req_data,
   output logic              rsp_valid,
   output blpw_pkg::rsp_type rsp_data
);
   import blpw_pkg::*;

   line_desc_type front_desc, queue_desc;
   logic          q_push, q_pop, q_full, q_empty;

   // Front end: accept and prepare each line.
   blpw_front #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_full   (q_full),
      .push     (q_push),
      .desc     (front_desc)
   );

   // Queue of prepared lines.
   blpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_desc),
      .pop       (q_pop),
      .pop_data  (queue_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back end: walk each line and emit address groups.
   blpw_walker #(
      .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .desc      (queue_desc),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
